>>> hw/rtl/rhr_pkg.sv
// Shared constants for the RGB hue rotation block.
`timescale 1ns / 1ps

package rhr_pkg;

    localparam int CH_W            = 8;      // one colour channel
    localparam int STEP_W          = 15;     // hue_step register width
    localparam int HUE_FRAC_DEF    = 6;      // default hue fraction bits
    localparam logic [STEP_W-1:0] STEP_RESET = 15'd32;

    // floor(y / 15) == (y * RECIP_15) >> RECIP_SHIFT for y < 3840
    localparam int Y_W             = 12;
    localparam int RECIP_W         = 13;
    localparam logic [RECIP_W-1:0] RECIP_15 = 13'd4370;
    localparam int RECIP_SHIFT     = 16;

    // sideband carried through the divider
    typedef struct packed {
        logic [CH_W-1:0] mx;
        logic [CH_W-1:0] mn;
        logic [CH_W-1:0] d;
        logic [2:0]      k;     // base sector multiple
        logic            neg;   // subtract ratio from base
    } rhr_side_t;

endpackage

>>> hw/rtl/rgb_hue_rotate_unit.sv
// Top level: RGB to HSV, hue advance with wrap to zero, back to RGB.
`timescale 1ns / 1ps

// Use: one pixel per transaction on the slave stream (s_*), one rotated
// pixel per transaction on the master stream (m_*). tdata carries red in
// the low byte, then green, then blue.
// The hue step is written through cfg_we / cfg_wdata, in 1/2^HUE_FRAC_BITS
// degree units; write it only while no pixel is in flight.
// Throughput: one pixel per clock while the output is not stalled.
// Pipeline from the accepting edge to m_tvalid: the input register takes
// the transaction at that edge, then come the divider load stage,
// QW = HUE_FRAC_BITS + 6 divider bit stages and six arithmetic stages.
// The depth is set by the bit-per-stage divider that forms the hue ratio.
// Stall: the whole pipeline holds while m_tvalid is high and m_tready is
// low; s_tready drops in the same cycle, so nothing is lost or repeated.
// The pipe moves as one: bubbles are not squeezed out during a stall.
// Reset: all valid bits clear, the hue step returns to 32 (half a degree).
// Grey pixels take hue zero and leave unchanged.

module rgb_hue_rotate_unit
    import rhr_pkg::*;
#(
    parameter int HUE_FRAC_BITS = HUE_FRAC_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,    // red_in, green_in, blue_in
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,    // red_out, green_out, blue_out
    input  logic              cfg_we,
    input  logic [STEP_W-1:0] cfg_wdata   // hue_step
);

    localparam int SECTOR_W = 60 << HUE_FRAC_BITS;
    localparam int FULL     = 6 * SECTOR_W;
    localparam int QW       = $clog2(SECTOR_W + 1);
    localparam int NW       = QW + CH_W;
    localparam int HW       = $clog2(FULL + (1 << STEP_W));

    localparam logic [HW-1:0] W_H    = HW'(SECTOR_W);
    localparam logic [HW-1:0] FULL_H = HW'(FULL);
    localparam logic [QW-1:0] W_Q    = QW'(SECTOR_W);
    localparam logic [NW-1:0] W_N    = NW'(SECTOR_W);
    localparam logic [NW-1:0] HALF_N = NW'(SECTOR_W / 2);

    // base sector multiples of the forward hue
    localparam logic [2:0] BASE_RED   = 3'd0;
    localparam logic [2:0] BASE_GREEN = 3'd2;
    localparam logic [2:0] BASE_BLUE  = 3'd4;
    localparam logic [2:0] BASE_TURN  = 3'd6;

    logic en;

    // ---- configuration ----
    logic [STEP_W-1:0] step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            step_reg <= cfg_wdata;
        end
    end

    // ---- stage A: input register ----
    logic            a_vld_reg;
    logic [CH_W-1:0] a_r_reg, a_g_reg, a_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_r_reg <= s_tdata[7:0];
            a_g_reg <= s_tdata[15:8];
            a_b_reg <= s_tdata[23:16];
        end
    end

    // max / min, sector choice and ratio numerator
    logic [CH_W-1:0] a_mx, a_mn, a_d, a_n;
    logic [2:0]      a_k;
    logic            a_neg;
    logic [NW-1:0]   a_num;
    rhr_side_t       a_side;

    always_comb
    begin
        a_mx = a_r_reg;
        if (a_g_reg > a_mx) a_mx = a_g_reg;
        if (a_b_reg > a_mx) a_mx = a_b_reg;
        a_mn = a_r_reg;
        if (a_g_reg < a_mn) a_mn = a_g_reg;
        if (a_b_reg < a_mn) a_mn = a_b_reg;
        a_d = a_mx - a_mn;

        // ties on the maximum go red, green, blue
        priority if (a_r_reg == a_mx)
        begin
            if (a_g_reg >= a_b_reg)
            begin
                a_n = a_g_reg - a_b_reg; a_k = BASE_RED;   a_neg = 1'b0;
            end
            else
            begin
                a_n = a_b_reg - a_g_reg; a_k = BASE_TURN;  a_neg = 1'b1;
            end
        end
        else if (a_g_reg == a_mx)
        begin
            if (a_b_reg >= a_r_reg)
            begin
                a_n = a_b_reg - a_r_reg; a_k = BASE_GREEN; a_neg = 1'b0;
            end
            else
            begin
                a_n = a_r_reg - a_b_reg; a_k = BASE_GREEN; a_neg = 1'b1;
            end
        end
        else
        begin
            if (a_r_reg >= a_g_reg)
            begin
                a_n = a_r_reg - a_g_reg; a_k = BASE_BLUE;  a_neg = 1'b0;
            end
            else
            begin
                a_n = a_g_reg - a_r_reg; a_k = BASE_BLUE;  a_neg = 1'b1;
            end
        end

        // grey: hue zero
        if (a_d == '0)
        begin
            a_k   = BASE_RED;
            a_neg = 1'b0;
        end

        a_num  = W_N * NW'(a_n) + NW'(a_d >> 1);
        a_side = '{mx: a_mx, mn: a_mn, d: a_d, k: a_k, neg: a_neg};
    end

    // ---- divider: q = round(W * n / d) ----
    logic          v_vld;
    logic [QW-1:0] v_q;
    rhr_side_t     v_side;

    rhr_div #(
        .QW (QW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_vld_reg),
        .num       (a_num),
        .den       (a_d),
        .side_in   (a_side),
        .out_valid (v_vld),
        .quo       (v_q),
        .side_out  (v_side)
    );

    // ---- stage B: forward hue ----
    logic            b_vld_reg;
    logic [HW-1:0]   b_hue_reg;
    logic [CH_W-1:0] b_mx_reg, b_mn_reg, b_d_reg;
    logic [HW-1:0]   b_base, b_q, b_hue_next;

    always_comb
    begin
        unique case (v_side.k)
            BASE_GREEN: b_base = HW'(2 * SECTOR_W);
            BASE_BLUE:  b_base = HW'(4 * SECTOR_W);
            BASE_TURN:  b_base = FULL_H;
            default:    b_base = '0;
        endcase
        b_q        = (v_side.d == '0) ? '0 : HW'(v_q);
        b_hue_next = v_side.neg ? (b_base - b_q) : (b_base + b_q);
    end

    // ---- stage C: hue advance, wrap to zero past a full turn ----
    logic            c_vld_reg;
    logic [HW-1:0]   c_hue_reg;
    logic [CH_W-1:0] c_mx_reg, c_mn_reg, c_d_reg;
    logic [HW-1:0]   c_sum;

    assign c_sum = b_hue_reg + HW'(step_reg);

    // ---- stage D: sector and offset ----
    logic            d_vld_reg;
    logic [2:0]      d_s_reg;
    logic [QW-1:0]   d_f_reg;
    logic [CH_W-1:0] d_mx_reg, d_mn_reg, d_d_reg;
    logic [2:0]      d_s;
    logic [HW-1:0]   d_off;

    // exactly a full turn lands in the last sector with a full offset
    always_comb
    begin
        priority if (c_hue_reg >= HW'(5 * SECTOR_W))
        begin
            d_s = 3'd5; d_off = HW'(5 * SECTOR_W);
        end
        else if (c_hue_reg >= HW'(4 * SECTOR_W))
        begin
            d_s = 3'd4; d_off = HW'(4 * SECTOR_W);
        end
        else if (c_hue_reg >= HW'(3 * SECTOR_W))
        begin
            d_s = 3'd3; d_off = HW'(3 * SECTOR_W);
        end
        else if (c_hue_reg >= HW'(2 * SECTOR_W))
        begin
            d_s = 3'd2; d_off = HW'(2 * SECTOR_W);
        end
        else if (c_hue_reg >= W_H)
        begin
            d_s = 3'd1; d_off = W_H;
        end
        else
        begin
            d_s = 3'd0; d_off = '0;
        end
    end

    // ---- stage E: scaled ramps, f*d and (W-f)*d plus rounding half ----
    logic            e_vld_reg;
    logic [2:0]      e_s_reg;
    logic [NW-1:0]   e_xu_reg, e_xd_reg;
    logic [CH_W-1:0] e_mx_reg, e_mn_reg;

    // ---- stage F: divide by W as shift then reciprocal of 15 ----
    logic            f_vld_reg;
    logic [2:0]      f_s_reg;
    logic [CH_W-1:0] f_up_reg, f_dn_reg;
    logic [CH_W-1:0] f_mx_reg, f_mn_reg;
    logic [Y_W-1:0]  f_yu, f_yd;
    logic [Y_W+RECIP_W-1:0] f_pu, f_pd;

    assign f_yu = e_xu_reg[HUE_FRAC_BITS+2 +: Y_W];
    assign f_yd = e_xd_reg[HUE_FRAC_BITS+2 +: Y_W];
    assign f_pu = (Y_W+RECIP_W)'(f_yu) * (Y_W+RECIP_W)'(RECIP_15);
    assign f_pd = (Y_W+RECIP_W)'(f_yd) * (Y_W+RECIP_W)'(RECIP_15);

    // ---- stage G: output register ----
    logic            g_vld_reg;
    logic [23:0]     g_data_reg;
    logic [CH_W-1:0] g_up, g_dn;
    logic [23:0]     g_data_next;

    always_comb
    begin
        g_up = f_mn_reg + f_up_reg;
        g_dn = f_mn_reg + f_dn_reg;
        unique case (f_s_reg)
            3'd0:    g_data_next = {f_mn_reg, g_up,     f_mx_reg};
            3'd1:    g_data_next = {f_mn_reg, f_mx_reg, g_dn};
            3'd2:    g_data_next = {g_up,     f_mx_reg, f_mn_reg};
            3'd3:    g_data_next = {f_mx_reg, g_dn,     f_mn_reg};
            3'd4:    g_data_next = {f_mx_reg, f_mn_reg, g_up};
            default: g_data_next = {g_dn,     f_mn_reg, f_mx_reg};
        endcase
    end

    // one enable for the whole pipe: hold only when the result is refused
    assign en       = !g_vld_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = g_vld_reg;
    assign m_tdata  = g_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b_vld_reg <= v_vld;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_hue_reg  <= b_hue_next;
            b_mx_reg   <= v_side.mx;
            b_mn_reg   <= v_side.mn;
            b_d_reg    <= v_side.d;

            c_hue_reg  <= (c_sum > FULL_H) ? '0 : c_sum;
            c_mx_reg   <= b_mx_reg;
            c_mn_reg   <= b_mn_reg;
            c_d_reg    <= b_d_reg;

            d_s_reg    <= d_s;
            d_f_reg    <= QW'(c_hue_reg - d_off);
            d_mx_reg   <= c_mx_reg;
            d_mn_reg   <= c_mn_reg;
            d_d_reg    <= c_d_reg;

            e_s_reg    <= d_s_reg;
            e_xu_reg   <= NW'(d_f_reg) * NW'(d_d_reg) + HALF_N;
            e_xd_reg   <= NW'(W_Q - d_f_reg) * NW'(d_d_reg) + HALF_N;
            e_mx_reg   <= d_mx_reg;
            e_mn_reg   <= d_mn_reg;

            f_s_reg    <= e_s_reg;
            f_up_reg   <= f_pu[RECIP_SHIFT +: CH_W];
            f_dn_reg   <= f_pd[RECIP_SHIFT +: CH_W];
            f_mx_reg   <= e_mx_reg;
            f_mn_reg   <= e_mn_reg;

            g_data_reg <= g_data_next;
        end
    end

`ifndef SYNTH
    a_hue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        d_vld_reg |-> (c_hue_reg <= FULL_H || !c_vld_reg))
        else $error("hue beyond a full turn after wrap");
    a_offset_in_sector: assert property (@(posedge clk) disable iff (!rst_n)
        e_vld_reg |-> (d_f_reg <= W_Q || !d_vld_reg))
        else $error("sector offset beyond one sector");
    a_ramp_within_span: assert property (@(posedge clk) disable iff (!rst_n)
        f_vld_reg |-> (f_up_reg <= f_mx_reg - f_mn_reg
                       && f_dn_reg <= f_mx_reg - f_mn_reg))
        else $error("ramp exceeds channel span");
    a_output_held: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(g_vld_reg))
        else $error("pipeline advanced while stalled");
`endif

endmodule

>>> hw/rtl/rhr_div.sv
// Pipelined restoring divider, one quotient bit per stage, 8-bit divisor.
`timescale 1ns / 1ps

module rhr_div
    import rhr_pkg::*;
#(
    parameter int QW = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [QW+CH_W-1:0]   num,
    input  logic [CH_W-1:0]      den,
    input  rhr_side_t            side_in,
    output logic                 out_valid,
    output logic [QW-1:0]        quo,
    output rhr_side_t            side_out
);

    localparam int NW = QW + CH_W;

    logic              vld_reg  [0:QW];
    logic [CH_W-1:0]   rem_reg  [0:QW];
    logic [NW-1:0]     num_reg  [0:QW];
    logic [QW-1:0]     quo_reg  [0:QW];
    logic [CH_W-1:0]   den_reg  [0:QW];
    rhr_side_t         side_reg [0:QW];

    // stage 0: load, high bits of the numerator are already below den
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num[NW-1:QW];
            num_reg[0]  <= num;
            quo_reg[0]  <= '0;
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [CH_W:0]   t;
        logic            ge;
        logic [CH_W-1:0] rem_next;

        always_comb
        begin
            t        = {rem_reg[i], num_reg[i][QW-1-i]};
            ge       = (t >= {1'b0, den_reg[i]});
            rem_next = ge ? CH_W'(t - {1'b0, den_reg[i]}) : t[CH_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= rem_next;
                num_reg[i+1]  <= num_reg[i];
                quo_reg[i+1]  <= {quo_reg[i][QW-2:0], ge};
                den_reg[i+1]  <= den_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign quo       = quo_reg[QW];
    assign side_out  = side_reg[QW];

`ifndef SYNTH
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[QW] && den_reg[QW] != '0) |-> (rem_reg[QW] < den_reg[QW]))
        else $error("divider remainder not below divisor");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg[QW]))
        else $error("divider moved while stalled");
    a_valid_travels: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> (vld_reg[1] == $past(vld_reg[0])))
        else $error("divider valid lost");
`endif

endmodule

>>> sim/rgb_hue_rotate_checker.sv
// Checker: predicts the rotated pixel for every accepted input and compares.
`timescale 1ns / 1ps

module rgb_hue_rotate_checker
    import rhr_pkg::*;
#(
    parameter int HUE_FRAC_BITS = HUE_FRAC_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [23:0]       s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [23:0]       m_tdata,
    input  logic              cfg_we,
    input  logic [STEP_W-1:0] cfg_wdata,
    output int                fail_count,
    output int                pending
);

    localparam int SECTOR = 60 << HUE_FRAC_BITS;
    localparam int TURN   = 6 * SECTOR;

    logic [STEP_W-1:0] step_q;
    logic [23:0]       pixel_q[$];

    function automatic int ratio(int n, int d);
        return (SECTOR * n + d / 2) / d;
    endfunction

    function automatic logic [23:0] rotate_pixel(logic [23:0] px, int step);
        int r, g, b, mx, mn, d, hue, s, f, up, dn, ro, go, bo;
        r = px[7:0]; g = px[15:8]; b = px[23:16];
        mx = r; mn = r; hue = 0;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (d != 0)
        begin
            if (r == mx)
                hue = (g >= b) ? ratio(g - b, d) : TURN - ratio(b - g, d);
            else if (g == mx)
                hue = (b >= r) ? 2*SECTOR + ratio(b - r, d)
                               : 2*SECTOR - ratio(r - b, d);
            else
                hue = (r >= g) ? 4*SECTOR + ratio(r - g, d)
                               : 4*SECTOR - ratio(g - r, d);
        end
        hue += step;
        if (hue > TURN) hue = 0;   // wrap to zero, not modulo
        s = hue / SECTOR;
        f = hue - s * SECTOR;
        if (s >= 6)
        begin
            s = 5; f = SECTOR;
        end
        up = mn + (f * d + SECTOR / 2) / SECTOR;
        dn = mn + ((SECTOR - f) * d + SECTOR / 2) / SECTOR;
        case (s)
            0: begin ro = mx; go = up; bo = mn; end
            1: begin ro = dn; go = mx; bo = mn; end
            2: begin ro = mn; go = mx; bo = up; end
            3: begin ro = mn; go = dn; bo = mx; end
            4: begin ro = up; go = mn; bo = mx; end
            default: begin ro = mx; go = mn; bo = dn; end
        endcase
        return {bo[7:0], go[7:0], ro[7:0]};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_q     <= STEP_RESET;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
                step_q <= cfg_wdata;
            if (s_tvalid && s_tready)
                pixel_q.push_back(rotate_pixel(s_tdata, step_q));
            if (m_tvalid && m_tready)
            begin
                if (pixel_q.size() == 0)
                begin
                    $display("%0t: unexpected pixel, expected none, actual %h",
                             $time, m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    logic [23:0] want;
                    int          bad;
                    want = pixel_q.pop_front();
                    bad  = 0;
                    for (int c = 0; c < 3; c++)
                        if (want[c*8 +: 8] !== m_tdata[c*8 +: 8])
                        begin
                            $display("%0t: channel %0d expected %0d actual %0d", $time,
                                     c, want[c*8 +: 8], m_tdata[c*8 +: 8]);
                            bad++;
                        end
                    if (bad != 0)
                        fail_count <= fail_count + 1;
                end
            end
            pending <= pixel_q.size();
        end
    end

endmodule

>>> sim/rgb_hue_rotate_unit_tb.sv
// Testbench top: stimulus, configuration phases and the verdict.
`timescale 1ns / 1ps

module rgb_hue_rotate_unit_tb;
    import rhr_pkg::*;

    localparam int LATENCY = HUE_FRAC_DEF + 13;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [23:0]       s_tdata;     // red_in, green_in, blue_in
    logic              m_tvalid;
    logic              m_tready;
    logic [23:0]       m_tdata;     // red_out, green_out, blue_out
    logic              cfg_we;
    logic [STEP_W-1:0] cfg_wdata;   // hue_step
    int                fail_count;
    int                pending;
    bit                calm;        // no idling in the final stretch

    rgb_hue_rotate_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    rgb_hue_rotate_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit: far beyond ~2050 pixels with worst-case gaps and stalls.
    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stall bursts, off in the final stretch.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // One pixel transaction; sender gap bursts held off only when calm.
    task automatic send_pixel(input logic [23:0] px);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Half grey or two-equal-channel pixels (ties for the max), half fully random.
    function automatic logic [23:0] random_pixel();
        logic [7:0] a, b2;
        case ($urandom_range(0, 5))
            0: begin a = 8'($urandom); return {a, a, a}; end
            1: begin a = 8'($urandom); b2 = 8'($urandom); return {b2, a, a}; end
            2: begin a = 8'($urandom); b2 = 8'($urandom); return {a, b2, a}; end
            default: return 24'($urandom);
        endcase
    endfunction

    // Steps: reset value, zero, exact full turn, above range, max field, two sectors, half a turn.
    logic [STEP_W-1:0] steps[7] = '{15'd32, 15'd0, 15'd23040, 15'd23041,
                                    15'h7FFF, 15'd7680, 15'd11520};

    initial
    begin
        logic [23:0] directed[$];
        rst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0;
        cfg_we = 1'b0; cfg_wdata = '0; calm = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: black, white, grey, primaries, secondaries, near-wrap hues.
        directed = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h0000FF, 24'h00FF00,
                     24'hFF0000, 24'h00FFFF, 24'hFF00FF, 24'hFFFF00, 24'h0100FF,
                     24'h0001FF, 24'hFE00FF, 24'h01FF00, 24'hFF0001, 24'h7F80FF,
                     24'h010203, 24'hFEFDFC, 24'h55AA00, 24'hAA0055};
        foreach (directed[i]) send_pixel(directed[i]);
        drain_pipe();

        foreach (steps[k])
        begin
            write_step(steps[k]);
            foreach (directed[i]) send_pixel(directed[i]);
            repeat (200) send_pixel(random_pixel());
            drain_pipe();   // sender waits for every result
        end

        write_step(STEP_W'($urandom_range(0, 23040)));
        repeat (300) send_pixel(random_pixel());
        calm = 1'b1;
        repeat (200) send_pixel(random_pixel());
        drain_pipe();

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
